FILE: hw/rtl/svalu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the small vector ALU.
package svalu_pkg;

    localparam int MAX_LEN   = 4;
    localparam int MIN_LEN   = 2;
    localparam int CROSS_LEN = 3;
    localparam int FRAC_BITS = 16;
    localparam int NUM_LANES = 4;
    localparam int DATA_W    = 32;
    localparam int LEN_W     = 3;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W + 3;

    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] SAT_MAX  =
        {{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_MIN  =
        {{(SUM_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

    typedef logic signed [DATA_W-1:0] elem_t;

    typedef enum logic [2:0] {
        REQ_LOAD     = 3'd0,
        REQ_SET_ELEM = 3'd1,
        REQ_SET_ALL  = 3'd2,
        REQ_ADD      = 3'd3,
        REQ_SUB      = 3'd4,
        REQ_CROSS    = 3'd5,
        REQ_SCALE    = 3'd6,
        REQ_DOT      = 3'd7
    } req_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_LOADED = 3'd1,
        ST_MISMATCH   = 3'd2,
        ST_CROSS3     = 3'd3,
        ST_BAD_LEN    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        MUL_NONE  = 2'd0,
        MUL_SCALE = 2'd1,
        MUL_CROSS = 2'd2,
        MUL_DOT   = 2'd3
    } mul_kind_t;

    typedef struct packed {
        elem_t a0;
        elem_t b0;
        elem_t a1;
        elem_t b1;
    } lane_op_t;

    typedef struct packed {
        elem_t value;
        logic  ovf;
    } rnd_t;

    typedef struct packed {
        status_t                  status;
        mul_kind_t                kind;
        logic                     ovf;
        logic [LEN_W-1:0]         len;
        elem_t [NUM_LANES-1:0]    acc;
    } stage_b_t;

    typedef struct packed {
        status_t                  status;
        elem_t                    dot_value;
        elem_t [NUM_LANES-1:0]    acc;
        logic [LEN_W-1:0]         acc_length;
        logic                     overflow;
    } out_word_t;

    function automatic logic len_ok(input logic [LEN_W-1:0] n);
        return (n >= LEN_W'(MIN_LEN)) && (n <= LEN_W'(MAX_LEN));
    endfunction

    // Round half up by dropping the fraction bits, then clamp to 32 bits.
    function automatic rnd_t round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        rnd_t r;
        t = v + RND_HALF;
        t = t >>> FRAC_BITS;
        if (t > SAT_MAX) begin
            r.value = SAT_MAX[DATA_W-1:0];
            r.ovf   = 1'b1;
        end else if (t < SAT_MIN) begin
            r.value = SAT_MIN[DATA_W-1:0];
            r.ovf   = 1'b1;
        end else begin
            r.value = t[DATA_W-1:0];
            r.ovf   = 1'b0;
        end
        return r;
    endfunction

    function automatic rnd_t sat_add(input elem_t a, input elem_t b, input logic sub);
        logic signed [DATA_W:0] s;
        rnd_t r;
        s = sub ? ((DATA_W + 1)'(a) - (DATA_W + 1)'(b))
                : ((DATA_W + 1)'(a) + (DATA_W + 1)'(b));
        if (s[DATA_W] != s[DATA_W-1]) begin
            r.value = s[DATA_W] ? SAT_MIN[DATA_W-1:0] : SAT_MAX[DATA_W-1:0];
            r.ovf   = 1'b1;
        end else begin
            r.value = s[DATA_W-1:0];
            r.ovf   = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/svalu_lane.sv
`timescale 1ns / 1ps
// One arithmetic lane: two registered products, their difference, rounded and clamped.
module svalu_lane
    import svalu_pkg::*;
(
    input  logic                    aclk,
    input  logic                    en,
    input  lane_op_t                op,
    output logic signed [SUM_W-1:0] sum,
    output rnd_t                    res
);

    logic signed [PROD_W-1:0] p0_reg;
    logic signed [PROD_W-1:0] p1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p0_reg <= $signed(op.a0) * $signed(op.b0);
            p1_reg <= $signed(op.a1) * $signed(op.b1);
        end
    end

    assign sum = SUM_W'(p0_reg) - SUM_W'(p1_reg);
    assign res = round_sat(sum);

endmodule

FILE: hw/rtl/svalu_merge.sv
`timescale 1ns / 1ps
// Combines the lane results into the final result word and accumulator update.
module svalu_merge
    import svalu_pkg::*;
(
    input  stage_b_t                b,
    input  logic signed [SUM_W-1:0] lane_sum [NUM_LANES],
    input  rnd_t                    lane_res [NUM_LANES],
    output out_word_t               word,
    output logic                    acc_wr
);

    logic signed [SUM_W-1:0] dot_sum;
    rnd_t                    dot_r;

    always_comb begin
        dot_sum = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            dot_sum = dot_sum + lane_sum[i];
        end
    end

    assign dot_r = round_sat(dot_sum);

    always_comb begin
        word.status     = b.status;
        word.dot_value  = '0;
        word.acc        = b.acc;
        word.acc_length = b.len;
        word.overflow   = b.ovf;
        acc_wr          = 1'b0;
        case (b.kind)
            MUL_SCALE: begin
                acc_wr = 1'b1;
                for (int i = 0; i < NUM_LANES; i++) begin
                    if (LEN_W'(i) < b.len) begin
                        word.acc[i]   = lane_res[i].value;
                        word.overflow = word.overflow | lane_res[i].ovf;
                    end
                end
            end
            MUL_CROSS: begin
                acc_wr = 1'b1;
                for (int i = 0; i < CROSS_LEN; i++) begin
                    word.acc[i]   = lane_res[i].value;
                    word.overflow = word.overflow | lane_res[i].ovf;
                end
            end
            MUL_DOT: begin
                word.dot_value = dot_r.value;
                word.overflow  = word.overflow | dot_r.ovf;
            end
            MUL_NONE: begin
                acc_wr = 1'b0;
            end
            default: begin
                acc_wr = 1'b0;
            end
        endcase
    end

endmodule

FILE: hw/rtl/small_vector_alu_unit.sv
`timescale 1ns / 1ps
// Small vector ALU: a Q16.16 accumulator vector of 2 to 4 elements with four parallel lanes.
//
// The unit takes one request word per cycle while s_ready is high and returns one result
// word for each: the request is decoded and the four lane multipliers are loaded at the
// accepting edge, the lane products are then summed, rounded and clamped, and the result
// then sits in the output register until it is taken. Load, set, add, subtract and dot
// requests settle the accumulator at acceptance, so the next word may be accepted while
// the previous one moves on to the output. Scale and cross product rewrite the
// accumulator from the multiplier stage, so the word after one of them is not accepted
// until it has left the middle stage. A stalled result word does not block acceptance
// until the middle stage is also full.
module small_vector_alu_unit
    import svalu_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_req_type,
    input  logic [2:0]         s_operand_length,
    input  logic signed [31:0] s_operand_x,
    input  logic signed [31:0] s_operand_y,
    input  logic signed [31:0] s_operand_z,
    input  logic signed [31:0] s_operand_w,
    input  logic signed [31:0] s_scalar_in,
    input  logic [1:0]         s_element_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic signed [31:0] m_dot_value,
    output logic signed [31:0] m_acc_x,
    output logic signed [31:0] m_acc_y,
    output logic signed [31:0] m_acc_z,
    output logic signed [31:0] m_acc_w,
    output logic [2:0]         m_acc_length,
    output logic               m_overflow
);

    elem_t [NUM_LANES-1:0] acc_reg;
    elem_t [NUM_LANES-1:0] acc_next;
    logic [LEN_W-1:0]      acc_len_reg;
    logic [LEN_W-1:0]      acc_len_next;
    logic                  b_valid_reg;
    stage_b_t              b_reg;
    stage_b_t              b_next;
    logic                  m_valid_reg;
    out_word_t             out_reg;
    out_word_t             merge_word;
    logic                  merge_acc_wr;

    elem_t                 op [NUM_LANES];
    lane_op_t              lane_op [NUM_LANES];
    logic signed [SUM_W-1:0] lane_sum [NUM_LANES];
    rnd_t                  lane_res [NUM_LANES];

    req_t                  req;
    logic                  accept;
    logic                  b_adv;
    logic                  b_writes;
    rnd_t                  add_r;

    assign op[0] = s_operand_x;
    assign op[1] = s_operand_y;
    assign op[2] = s_operand_z;
    assign op[3] = s_operand_w;
    assign req   = req_t'(s_req_type);

    always_comb begin
        b_next.status = ST_OK;
        b_next.kind   = MUL_NONE;
        b_next.ovf    = 1'b0;
        acc_next      = acc_reg;
        acc_len_next  = acc_len_reg;
        add_r         = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            lane_op[i] = '0;
        end
        if (req == REQ_LOAD) begin
            if (!len_ok(s_operand_length)) begin
                b_next.status = ST_BAD_LEN;
            end else begin
                acc_len_next = s_operand_length;
                for (int i = 0; i < NUM_LANES; i++) begin
                    acc_next[i] = (LEN_W'(i) < s_operand_length) ? op[i] : '0;
                end
            end
        end else if (acc_len_reg == '0) begin
            b_next.status = ST_NOT_LOADED;
        end else if (req == REQ_SET_ELEM) begin
            if ({1'b0, s_element_index} < acc_len_reg) begin
                acc_next[s_element_index] = s_scalar_in;
            end
        end else if (req == REQ_SET_ALL) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                if (LEN_W'(i) < acc_len_reg) begin
                    acc_next[i] = s_scalar_in;
                end
            end
        end else if (req == REQ_SCALE) begin
            b_next.kind = MUL_SCALE;
            for (int i = 0; i < NUM_LANES; i++) begin
                lane_op[i].a0 = acc_reg[i];
                lane_op[i].b0 = s_scalar_in;
            end
        end else if (!len_ok(s_operand_length)) begin
            b_next.status = ST_BAD_LEN;
        end else if (s_operand_length != acc_len_reg) begin
            b_next.status = ST_MISMATCH;
        end else if ((req == REQ_ADD) || (req == REQ_SUB)) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                if (LEN_W'(i) < acc_len_reg) begin
                    add_r       = sat_add(acc_reg[i], op[i], req == REQ_SUB);
                    acc_next[i] = add_r.value;
                    b_next.ovf  = b_next.ovf | add_r.ovf;
                end
            end
        end else if (req == REQ_CROSS) begin
            if (acc_len_reg != LEN_W'(CROSS_LEN)) begin
                b_next.status = ST_CROSS3;
            end else begin
                b_next.kind   = MUL_CROSS;
                lane_op[0].a0 = acc_reg[1];
                lane_op[0].b0 = op[2];
                lane_op[0].a1 = acc_reg[2];
                lane_op[0].b1 = op[1];
                lane_op[1].a0 = acc_reg[2];
                lane_op[1].b0 = op[0];
                lane_op[1].a1 = acc_reg[0];
                lane_op[1].b1 = op[2];
                lane_op[2].a0 = acc_reg[0];
                lane_op[2].b0 = op[1];
                lane_op[2].a1 = acc_reg[1];
                lane_op[2].b1 = op[0];
            end
        end else begin
            b_next.kind = MUL_DOT;
            for (int i = 0; i < NUM_LANES; i++) begin
                if (LEN_W'(i) < acc_len_reg) begin
                    lane_op[i].a0 = acc_reg[i];
                    lane_op[i].b0 = op[i];
                end
            end
        end
        b_next.len = acc_len_next;
        b_next.acc = acc_next;
    end

    assign b_writes = (b_reg.kind == MUL_SCALE) || (b_reg.kind == MUL_CROSS);
    assign b_adv    = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !b_valid_reg || (b_adv && !b_writes);
    assign accept   = s_valid && s_ready;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        svalu_lane u_lane (
            .aclk (aclk),
            .en   (accept),
            .op   (lane_op[g]),
            .sum  (lane_sum[g]),
            .res  (lane_res[g])
        );
    end

    svalu_merge u_merge (
        .b        (b_reg),
        .lane_sum (lane_sum),
        .lane_res (lane_res),
        .word     (merge_word),
        .acc_wr   (merge_acc_wr)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            acc_len_reg <= '0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                acc_reg     <= acc_next;
                acc_len_reg <= acc_len_next;
                b_valid_reg <= 1'b1;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv) begin
                m_valid_reg <= 1'b1;
                if (merge_acc_wr) begin
                    acc_reg <= merge_word.acc;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_reg <= b_next;
        end
        if (b_adv) begin
            out_reg <= merge_word;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = out_reg.status;
    assign m_dot_value  = out_reg.dot_value;
    assign m_acc_x      = out_reg.acc[0];
    assign m_acc_y      = out_reg.acc[1];
    assign m_acc_z      = out_reg.acc[2];
    assign m_acc_w      = out_reg.acc[3];
    assign m_acc_length = out_reg.acc_length;
    assign m_overflow   = out_reg.overflow;

endmodule
